// File: hdl/lrucwb_pkg.sv
// Shared types and constants for the LRU cache with victim write-back.
// Request/response beats, state encoding and scan status flags.
// No dependencies.
package lrucwb_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               miss_to_backing;
    logic               victim_valid;
    logic [KEY_W-1:0]   victim_key;
    logic [VALUE_W-1:0] victim_value;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic hit;
    logic free_ok;
    logic vic_ok;
  } scan_flags_t;

endpackage

// File: hdl/lru_cache_with_victim_writeback_core.sv
// LRU key/value cache with victim write-back, one shared key compare per cycle.
// Steps: the start beat is taken in idle, every entry is scanned, then the read and response
// states follow and the result strobe is registered. Items are not overlapped: the key store's
// single read port scans one entry per cycle; a new start is taken as the strobe ends.
// Reset: all entries invalid, occupancy zero, capacity 16; the receiver cannot stall.
module lru_cache_with_victim_writeback_core
  import lrucwb_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  state_t               state, state_next;
  logic [CW-1:0]        cnt;
  op_t                  op_q;
  logic [KEY_W-1:0]     key_in;
  logic [VALUE_W-1:0]   val_in;
  logic [CAP_W-1:0]     cap;
  logic [CW-1:0]        occ;
  logic [MAX_ENTRIES-1:0] valid;
  logic [IW-1:0]        age [MAX_ENTRIES];

  logic [KEY_W-1:0]     key_mem [MAX_ENTRIES];
  logic [VALUE_W-1:0]   val_mem [MAX_ENTRIES];
  logic [KEY_W-1:0]     key_rd;
  logic [VALUE_W-1:0]   val_rd;
  logic [IW-1:0]        key_addr;
  logic [IW-1:0]        sel_slot;

  logic                 ev_on;
  logic [IW-1:0]        ev_idx;

  scan_flags_t          flags;
  logic [IW-1:0]        hit_slot, hit_age, free_slot, vic_slot;

  logic [EW-1:0]        eff_cap;
  logic                 evict;
  logic                 slot_ok;
  logic [IW-1:0]        ins_slot;
  logic [IW-1:0]        wr_slot;
  logic                 do_touch, do_insert, do_val_wr;
  logic                 accept;
  logic                 scan_last;
  logic                 done_next;
  rsp_t                 rsp_next;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign scan_last = (cnt == CW'(MAX_ENTRIES));

  lrucwb_scan #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (accept),
    .beat      (ev_on),
    .idx       (ev_idx),
    .valid     (valid[ev_idx]),
    .age       (age[ev_idx]),
    .key_match (key_rd == key_in),
    .flags     (flags),
    .hit_slot  (hit_slot),
    .hit_age   (hit_age),
    .free_slot (free_slot),
    .vic_slot  (vic_slot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (scan_last) state_next = ST_READ;
      ST_READ: state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    done_next = (state == ST_RESP);

    if (cap == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap) > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = EW'(cap);
    end

    evict    = (op_q == OP_PUT) && !flags.hit && flags.vic_ok &&
               (EW'(occ) >= eff_cap) && (occ != '0);
    slot_ok  = evict || flags.free_ok;
    ins_slot = (evict && (!flags.free_ok || vic_slot < free_slot)) ? vic_slot : free_slot;
    sel_slot = flags.hit ? hit_slot : vic_slot;
    key_addr = (state == ST_SCAN) ? cnt[IW-1:0] : sel_slot;
    wr_slot  = flags.hit ? hit_slot : ins_slot;

    do_touch  = (state == ST_RESP) && flags.hit;
    do_insert = (state == ST_RESP) && (op_q == OP_PUT) && !flags.hit && slot_ok;
    do_val_wr = (do_touch && (op_q == OP_PUT)) || do_insert;

    rsp_next = '0;
    if (op_q == OP_GET) begin
      if (flags.hit) begin
        rsp_next.hit        = 1'b1;
        rsp_next.read_value = val_rd;
      end else begin
        rsp_next.miss_to_backing = 1'b1;
      end
    end else if (flags.hit) begin
      rsp_next.hit = 1'b1;
    end else if (evict) begin
      rsp_next.victim_valid = 1'b1;
      rsp_next.victim_key   = key_rd;
      rsp_next.victim_value = val_rd;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      ev_on <= 1'b0;
      cap   <= CAP_RESET;
      occ   <= '0;
      valid <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      ev_on <= (state == ST_SCAN) && !scan_last;
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (do_touch) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (IW'(i) == hit_slot) begin
            age[i] <= '0;
          end else if (valid[i] && age[i] < hit_age) begin
            age[i] <= age[i] + 1'b1;
          end
        end
      end
      if (do_insert) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (IW'(i) == ins_slot) begin
            age[i]   <= '0;
            valid[i] <= 1'b1;
          end else if (evict && IW'(i) == vic_slot) begin
            valid[i] <= 1'b0;
          end else if (valid[i]) begin
            age[i] <= age[i] + 1'b1;
          end
        end
        if (!evict) begin
          occ <= occ + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.op;
      key_in <= req.key;
      val_in <= req.value;
      cnt    <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end
    ev_idx <= cnt[IW-1:0];
    if (state == ST_RESP) begin
      rsp <= rsp_next;
    end
  end

  // key and value stores
  always_ff @(posedge clk) begin
    key_rd <= key_mem[key_addr];
    val_rd <= val_mem[sel_slot];
    if (do_insert) begin
      key_mem[ins_slot] <= key_in;
    end
    if (do_val_wr) begin
      val_mem[wr_slot] <= val_in;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_busy_ends_with_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(occ))
    else $error("occupancy out of step with valid marks");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(MAX_ENTRIES))
    else $error("occupancy above entry count");

endmodule

// File: hdl/lrucwb_scan.sv
// Entry scan tracker: takes one entry per beat and keeps the matching slot,
// the lowest free slot and the oldest valid slot.
// Depends on lrucwb_pkg.
module lrucwb_scan
  import lrucwb_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               beat,
  input  logic [$clog2(MAX_ENTRIES)-1:0]     idx,
  input  logic                               valid,
  input  logic [$clog2(MAX_ENTRIES)-1:0]     age,
  input  logic                               key_match,
  output scan_flags_t                        flags,
  output logic [$clog2(MAX_ENTRIES)-1:0]     hit_slot,
  output logic [$clog2(MAX_ENTRIES)-1:0]     hit_age,
  output logic [$clog2(MAX_ENTRIES)-1:0]     free_slot,
  output logic [$clog2(MAX_ENTRIES)-1:0]     vic_slot
);

  localparam int IW = $clog2(MAX_ENTRIES);

  logic [IW-1:0] vic_age;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (clear) begin
      flags <= '0;
    end else if (beat) begin
      if (valid && key_match && !flags.hit) begin
        flags.hit <= 1'b1;
      end
      if (!valid && !flags.free_ok) begin
        flags.free_ok <= 1'b1;
      end
      if (valid && (!flags.vic_ok || age > vic_age)) begin
        flags.vic_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat && !clear) begin
      if (valid && key_match && !flags.hit) begin
        hit_slot <= idx;
        hit_age  <= age;
      end
      if (!valid && !flags.free_ok) begin
        free_slot <= idx;
      end
      if (valid && (!flags.vic_ok || age > vic_age)) begin
        vic_slot <= idx;
        vic_age  <= age;
      end
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear |=> (flags == '0))
    else $error("scan flags not cleared");

endmodule

// File: dv/lru_cache_with_victim_writeback_core_tb.sv
// Self-checking bench for lru_cache_with_victim_writeback_core: a directed table, then random
// put/get traffic over small key pools at several capacities, checked against a local LRU shadow.
// Depends on lrucwb_pkg and the core only.
`timescale 1ns / 100ps

module lru_cache_with_victim_writeback_core_tb;
  import lrucwb_pkg::*;

  localparam int ENTRIES = 16;

  typedef enum {ROW_ITEM, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    req_t             rq;
    logic [CAP_W-1:0] cap;
    bit               pinned;
    rsp_t             want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             done;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  bit   pin_valid = 1'b0;
  rsp_t pin_rsp = '0;

  logic [KEY_W-1:0]   slot_key   [ENTRIES];
  logic [VALUE_W-1:0] slot_value [ENTRIES];
  bit                 slot_valid [ENTRIES];
  int unsigned        slot_age   [ENTRIES];
  int unsigned        occupied = 0;
  logic [CAP_W-1:0]   cap_shadow = CAP_RESET;

  rsp_t      pending_rsp [$];
  stim_row_t plan [$];
  int        fail_count = 0;

  lru_cache_with_victim_writeback_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned eff_capacity(logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > ENTRIES) return ENTRIES;
    return c;
  endfunction

  function automatic void make_newest(int s);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic rsp_t cache_access(req_t r);
    rsp_t        o;
    int          s;
    int          slot;
    int          victim;
    int unsigned oldest;
    o = '0;
    s = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (s < 0 && slot_valid[i] && slot_key[i] == r.key) s = i;
    end
    if (r.op == OP_GET) begin
      if (s >= 0) begin
        o.hit = 1'b1;
        o.read_value = slot_value[s];
        make_newest(s);
      end else begin
        o.miss_to_backing = 1'b1;
      end
    end else if (s >= 0) begin
      o.hit = 1'b1;
      slot_value[s] = r.value;
      make_newest(s);
    end else begin
      if (occupied >= eff_capacity(cap_shadow) && occupied > 0) begin
        victim = -1;
        oldest = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_age[i] > oldest)) begin
            victim = i;
            oldest = slot_age[i];
          end
        end
        if (victim >= 0) begin
          o.victim_valid = 1'b1;
          o.victim_key = slot_key[victim];
          o.victim_value = slot_value[victim];
          slot_valid[victim] = 1'b0;
          occupied--;
        end
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !slot_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) slot_age[i]++;
        end
        slot_key[slot] = r.key;
        slot_value[slot] = r.value;
        slot_valid[slot] = 1'b1;
        slot_age[slot] = 0;
        occupied++;
      end
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (pending_rsp.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_count++;
        end else begin
          want = pending_rsp.pop_front();
          check_field("hit", want.hit, rsp.hit);
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("miss_to_backing", want.miss_to_backing, rsp.miss_to_backing);
          check_field("victim_valid", want.victim_valid, rsp.victim_valid);
          check_field("victim_key", want.victim_key, rsp.victim_key);
          check_field("victim_value", want.victim_value, rsp.victim_value);
        end
      end
      if (start && !busy) begin
        want = cache_access(req);
        if (pin_valid) want = pin_rsp;
        pending_rsp.push_back(want);
      end
      if (cfg_valid && cfg_ready) cap_shadow = cfg_data;
    end
  end

  function automatic void add_item(op_t op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                                   bit pinned = 1'b0, rsp_t want = '0);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.rq = req_t'{op, k, v};
    row.cap = '0;
    row.pinned = pinned;
    row.want = want;
    plan.push_back(row);
  endfunction

  function automatic void add_cap(logic [CAP_W-1:0] c);
    stim_row_t row;
    row.kind = ROW_CAP;
    row.rq = '0;
    row.cap = c;
    row.pinned = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  // hold start and the beat until taken, return at the following falling edge
  task automatic issue(input req_t r, input bit pinned, input rsp_t want);
    start = 1'b1;
    req = r;
    pin_valid = pinned;
    pin_rsp = want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    start = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = c;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    req_t             r;
    logic [CAP_W-1:0] cap;
    logic [KEY_W-1:0] key_pool [24];
    int               pool_n;
    int               wait_cycles;
    logic [CAP_W-1:0] cap_plan [5];

    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_valid[i] = 1'b0;
      slot_age[i] = 0;
    end
    cap_plan = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd2};

    add_item(OP_GET, 32'h0, 32'h0, 1'b1, rsp_t'{1'b0, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0});
    add_item(OP_PUT, 32'h0, 32'h0, 1'b1, '0);
    add_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
    add_item(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
             rsp_t'{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0});
    add_item(OP_PUT, 32'h0, 32'hA5A5_A5A5, 1'b1, rsp_t'{1'b1, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0});
    add_item(OP_GET, 32'h0, 32'hFFFF_FFFF, 1'b1,
             rsp_t'{1'b1, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0, 32'h0});
    add_cap(5'd1);
    add_item(OP_PUT, 32'h1, 32'h11, 1'b1,
             rsp_t'{1'b0, 32'h0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    add_item(OP_PUT, 32'h2, 32'h22, 1'b1,
             rsp_t'{1'b0, 32'h0, 1'b0, 1'b1, 32'h0, 32'hA5A5_A5A5});
    add_cap(5'd0);
    add_item(OP_PUT, 32'h3, 32'h33, 1'b1, rsp_t'{1'b0, 32'h0, 1'b0, 1'b1, 32'h1, 32'h11});
    add_item(OP_GET, 32'h2, 32'h0);
    add_cap(5'd31);
    for (int i = 0; i < 14; i++) add_item(OP_PUT, 32'h100 + i, $urandom);
    add_item(OP_PUT, 32'h200, 32'h5A5A_5A5A, 1'b1,
             rsp_t'{1'b0, 32'h0, 1'b0, 1'b1, 32'h3, 32'h33});

    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAP) begin
        set_capacity(plan[i].cap);
      end else begin
        issue(plan[i].rq, plan[i].pinned, plan[i].want);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      cap = (ph < 5) ? cap_plan[ph] : CAP_W'($urandom_range(0, 31));
      set_capacity(cap);
      pool_n = eff_capacity(cap) + $urandom_range(0, 6);
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 9))
          0: key_pool[i] = '0;
          1: key_pool[i] = '1;
          default: key_pool[i] = $urandom;
        endcase
      end
      for (int n = 0; n < 100; n++) begin
        if (ph < 8 && $urandom_range(0, 3) == 0) begin
          start = 1'b0;
          repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        r.op = op_t'($urandom_range(0, 1));
        r.key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, pool_n - 1)];
        r.value = $urandom;
        issue(r, 1'b0, '0);
      end
    end

    start = 1'b0;
    wait_cycles = 0;
    while (pending_rsp.size() != 0 && wait_cycles < 2000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (25) @(negedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d results never arrived", pending_rsp.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
